[design/dspm_pkg.sv]
`timescale 1ns / 1ps

package dspm_pkg;

    // pattern capacity and derived widths
    localparam int MAX_PATTERN = 32;
    localparam int NPOS        = MAX_PATTERN + 1;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int NLVL        = $clog2(NPOS);

    // special pattern symbols
    localparam logic [7:0] SYM_WILD   = 8'd46;
    localparam logic [7:0] SYM_REPEAT = 8'd42;

    // input function codes
    localparam logic [1:0] FUNC_PATTERN = 2'd0;
    localparam logic [1:0] FUNC_SUBJECT = 2'd1;
    localparam logic [1:0] FUNC_FINISH  = 2'd2;

    typedef enum logic [1:0] {
        OP_PATTERN,
        OP_SUBJECT,
        OP_FINISH
    } t_op_kind;

    // one classified operation as it travels through the queue
    typedef struct packed {
        t_op_kind   kind;
        logic       restart;
        logic [7:0] symbol;
    } t_op;

    // queue status toward front and back
    typedef struct packed {
        logic not_empty;
        logic full;
    } t_q_status;

endpackage

[design/dot_star_pattern_matcher.sv]
`timescale 1ns / 1ps

// Whole-string matcher for patterns of literal bytes, '.' (any byte) and '*' (zero or
// more of the element before it). Send pattern bytes with func 0 (restart clears the
// pattern and the overflow flag first), then subject bytes with func 1, then a finish
// with func 2, which returns one transaction with matched and overflow and sends the
// automaton back to its start set. Restart on a subject byte or finish starts a fresh
// subject; func 3 is accepted and ignored. Up to 32 pattern elements are held; extra
// elements are dropped and overflow stays set until the next pattern restart. Every
// item is accepted and a new one may follow each cycle while the queue has room:
// the whole automaton step (closure over all positions plus the byte compare) is one
// register update. A two-entry queue sits between input decode and the engine, so
// input keeps flowing while a result waits until the queue fills; only a finish
// stalls the engine, and only while the previous result has not been taken. A finish
// passes through the queue and then sets the result register.
module dot_star_pattern_matcher
    import dspm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [0] restart, [8:1] symbol, [15:9] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [0] matched, [1] overflow, [7:2] zero
);

    t_q_status  q_status;
    t_op        push_op;
    t_op        head_op;
    logic       push;
    logic       pop;
    logic [1:0] res_data;

    // input decode
    dspm_front u_front (
        .i_tvalid   (s_axis_tvalid),
        .i_func     (s_axis_tuser),
        .i_restart  (s_axis_tdata[0]),
        .i_symbol   (s_axis_tdata[8:1]),
        .i_q_status (q_status),
        .o_tready   (s_axis_tready),
        .o_push     (push),
        .o_op       (push_op)
    );

    // decoupling queue
    dspm_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_op     (push_op),
        .i_pop    (pop),
        .o_status (q_status),
        .o_op     (head_op)
    );

    // matching engine and result register
    dspm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_op       (head_op),
        .i_m_tready (m_axis_tready),
        .o_pop      (pop),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_data   (res_data)
    );

    assign m_axis_tdata = {6'd0, res_data};

endmodule

[design/dspm_front.sv]
`timescale 1ns / 1ps

module dspm_front
    import dspm_pkg::*;
(
    input  logic       i_tvalid,
    input  logic [1:0] i_func,
    input  logic       i_restart,
    input  logic [7:0] i_symbol,
    input  t_q_status  i_q_status,
    output logic       o_tready,
    output logic       o_push,
    output t_op        o_op
);

    logic keep;

    // decode the function code; the unused code is taken and dropped
    always_comb begin
        keep       = 1'b1;
        o_op.kind  = OP_PATTERN;
        case (i_func)
            FUNC_PATTERN: begin
                o_op.kind = OP_PATTERN;
            end
            FUNC_SUBJECT: begin
                o_op.kind = OP_SUBJECT;
            end
            FUNC_FINISH: begin
                o_op.kind = OP_FINISH;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
        o_op.restart = i_restart;
        o_op.symbol  = i_symbol;
    end

    // accept whenever the queue has room
    assign o_tready = ~i_q_status.full;
    assign o_push   = i_tvalid & o_tready & keep;

endmodule

[design/dspm_queue.sv]
`timescale 1ns / 1ps

module dspm_queue
    import dspm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_op       i_op,
    input  logic      i_pop,
    output t_q_status o_status,
    output t_op       o_op
);

    t_op        r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       do_push;
    logic       do_pop;

    assign o_status.not_empty = (r_count != 2'd0);
    assign o_status.full      = (r_count == 2'd2);
    assign o_op               = r_mem[r_rd_ptr];

    assign do_push = i_push & ~o_status.full;
    assign do_pop  = i_pop & o_status.not_empty;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = do_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (!do_push && do_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

endmodule

[design/dspm_back.sv]
`timescale 1ns / 1ps

module dspm_back
    import dspm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_status  i_q_status,
    input  t_op        i_op,
    input  logic       i_m_tready,
    output logic       o_pop,
    output logic       o_m_tvalid,
    output logic [1:0] o_m_data
);

    localparam logic [NPOS-1:0] START_SET = NPOS'(1);

    logic [7:0]             r_sym [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] r_wild;
    logic [MAX_PATTERN-1:0] r_marks, n_marks;
    logic [LEN_W-1:0]       r_len, n_len;
    logic                   r_ovf, n_ovf;
    logic [NPOS-1:0]        r_active, n_active;
    logic                   r_out_valid, n_out_valid;
    logic [1:0]             r_out_data, n_out_data;

    logic [MAX_PATTERN-1:0] elem_mask;
    logic [NPOS-1:0]        upto_mask;
    logic [MAX_PATTERN-1:0] hit;
    logic [NPOS-1:0]        base_set;
    logic [NPOS-1:0]        g_lvl [NLVL+1];
    logic [NPOS-1:0]        p_lvl [NLVL+1];
    logic [NPOS-1:0]        cur_set;
    logic [MAX_PATTERN-1:0] take;
    logic [MAX_PATTERN-1:0] stay;
    logic [MAX_PATTERN-1:0] adv;
    logic [NPOS-1:0]        step_set;
    logic                   matched;

    logic [LEN_W-1:0]       len_eff;
    logic [LEN_W-1:0]       len_m1;
    logic [MAX_PATTERN-1:0] marks_eff;
    logic [IDX_W-1:0]       last_idx;
    logic [IDX_W-1:0]       wr_idx;
    logic                   is_mark;
    logic                   has_room;
    logic                   sym_we;
    logic                   is_fin;

    // element and position masks from the current length
    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            elem_mask[k] = (LEN_W'(k) < r_len);
            hit[k]       = elem_mask[k] & (r_wild[k] | (r_sym[k] == i_op.symbol));
        end
        for (int k = 0; k < NPOS; k++) begin
            upto_mask[k] = (LEN_W'(k) <= r_len);
        end
    end

    // epsilon closure as a parallel prefix: a marked element passes its bit on
    always_comb begin
        base_set = i_op.restart ? START_SET : r_active;
        g_lvl[0] = base_set;
        p_lvl[0] = {r_marks & elem_mask, 1'b0};
        for (int l = 0; l < NLVL; l++) begin
            for (int i = 0; i < NPOS; i++) begin
                if (i >= (1 << l)) begin
                    g_lvl[l+1][i] = g_lvl[l][i] | (p_lvl[l][i] & g_lvl[l][i - (1 << l)]);
                    p_lvl[l+1][i] = p_lvl[l][i] & p_lvl[l][i - (1 << l)];
                end else begin
                    g_lvl[l+1][i] = g_lvl[l][i];
                    p_lvl[l+1][i] = p_lvl[l][i];
                end
            end
        end
        cur_set = g_lvl[NLVL];
    end

    // one subject byte: a marked element keeps its position, others advance
    always_comb begin
        take     = cur_set[MAX_PATTERN-1:0] & hit;
        stay     = take & r_marks;
        adv      = take & ~r_marks;
        step_set = {adv, 1'b0} | {1'b0, stay};
        matched  = cur_set[r_len];
    end

    // pattern append decisions
    always_comb begin
        len_eff   = i_op.restart ? '0 : r_len;
        marks_eff = i_op.restart ? '0 : r_marks;
        len_m1    = len_eff - LEN_W'(1);
        last_idx  = len_m1[IDX_W-1:0];
        wr_idx    = len_eff[IDX_W-1:0];
        is_mark   = (i_op.symbol == SYM_REPEAT) && (len_eff != '0) && !marks_eff[last_idx];
        has_room  = (len_eff < LEN_W'(MAX_PATTERN));
    end

    // pop rule: a finish waits for the result register
    assign is_fin = (i_op.kind == OP_FINISH);
    assign o_pop  = i_q_status.not_empty & (!is_fin || !r_out_valid || i_m_tready);

    // execute the popped operation
    always_comb begin
        n_marks     = r_marks;
        n_len       = r_len;
        n_ovf       = r_ovf;
        n_active    = r_active;
        sym_we      = 1'b0;
        n_out_valid = r_out_valid & ~i_m_tready;
        n_out_data  = r_out_data;
        if (o_pop) begin
            case (i_op.kind)
                OP_PATTERN: begin
                    n_marks  = marks_eff;
                    n_len    = len_eff;
                    n_ovf    = i_op.restart ? 1'b0 : r_ovf;
                    n_active = START_SET;
                    if (is_mark) begin
                        n_marks[last_idx] = 1'b1;
                    end else if (has_room) begin
                        n_marks[wr_idx] = 1'b0;
                        n_len           = len_eff + LEN_W'(1);
                        sym_we          = 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                OP_SUBJECT: begin
                    n_active = step_set;
                end
                OP_FINISH: begin
                    n_active    = START_SET;
                    n_out_valid = 1'b1;
                    n_out_data  = {r_ovf, matched};
                end
                default: begin
                    n_active = r_active;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marks     <= '0;
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_active    <= START_SET;
            r_out_valid <= 1'b0;
        end else begin
            r_marks     <= n_marks;
            r_len       <= n_len;
            r_ovf       <= n_ovf;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    // pattern symbol store and result payload
    always_ff @(posedge i_clk) begin
        if (sym_we) begin
            r_sym[wr_idx]  <= i_op.symbol;
            r_wild[wr_idx] <= (i_op.symbol == SYM_WILD);
        end
        r_out_data <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_data   = r_out_data;

    // active positions never lie beyond the pattern end
    a_active_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active & ~upto_mask) == '0)
        else $error("active position beyond pattern length");

    // repeat marks only on loaded elements
    a_marks_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_marks & ~elem_mask) == '0)
        else $error("repeat mark beyond pattern length");

    // a finish returns the automaton to the start set
    a_finish_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && is_fin) |=> (r_active == START_SET) && r_out_valid)
        else $error("finish did not restart the automaton");

    // a finish is never executed over an unaccepted result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && is_fin) |-> (!r_out_valid || i_m_tready))
        else $error("result overwritten while stalled");

    // length stays within capacity
    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(MAX_PATTERN))
        else $error("pattern length above capacity");

endmodule
